[rtl/core/tcw_pkg.sv]
// text console writer package: item types, control structs and constants
// shared by the cursor, the top level and the testbench; depends on nothing
`timescale 1ns / 1ps

package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] NULL_CODE    = 8'd0;
  localparam logic       MODE_PUT     = 1'b0;
  localparam logic       MODE_READ    = 1'b1;

  // attribute byte after reset
  localparam logic [7:0] COLOR_RESET  = 8'd3;

  // request on the input channel
  typedef struct packed {
    logic        mode;
    logic [7:0]  char_code;
    logic [10:0] read_index;
  } in_item_t;

  // result item on the result channel
  typedef struct packed {
    logic [15:0] cell_data;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } out_item_t;

  // cursor update commands from the control sequencer
  typedef struct packed {
    logic advance;
    logic newline;
    logic scroll;
  } cur_cmd_t;

  // cursor status back to the control sequencer
  typedef struct packed {
    logic col_full;
    logic at_bottom;
    logic read_ok;
  } cur_stat_t;

endpackage

[rtl/core/tcw_ram.sv]
// generic single write port, single read port ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/tcw_cursor.sv]
// cursor and screen origin registers with logical to physical address mapping
// the cell store is a ring of rows; depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS),
  localparam int COL_W  = $clog2(COLUMNS + 1),
  localparam int ROW_W  = $clog2(ROWS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::cur_cmd_t  cmd,
  input  logic [10:0]        read_index,
  output tcw_pkg::cur_stat_t stat,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      rd_addr,
  output logic [AW-1:0]      top_addr,
  output logic [COL_W-1:0]   col_nxt,
  output logic [ROW_W-1:0]   row_nxt
);

  // sum width: holds any index plus an offset below the cell count
  localparam int SW = ((AW > 11) ? AW : 11) + 1;

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [AW-1:0]    row_base_r;
  logic [AW-1:0]    base_off_r;
  logic [AW-1:0]    row_base_nxt;
  logic [AW-1:0]    base_off_nxt;
  logic [SW-1:0]    wr_sum;
  logic [SW-1:0]    rd_sum;
  logic [SW-1:0]    bo_sum;

  // status flags
  assign stat.col_full  = (col_r == COL_W'(COLUMNS));
  assign stat.at_bottom = (row_r == ROW_W'(ROWS - 1));
  assign stat.read_ok   = (SW'(read_index) < SW'(CELLS));

  // physical write address of the cursor cell, wrapped once
  assign wr_sum  = SW'(row_base_r) + SW'(col_r) + SW'(base_off_r);
  assign wr_addr = (wr_sum >= SW'(CELLS)) ? AW'(wr_sum - SW'(CELLS)) : AW'(wr_sum);

  // physical read address of a logical cell index, wrapped once
  assign rd_sum  = SW'(read_index) + SW'(base_off_r);
  assign rd_addr = (rd_sum >= SW'(CELLS)) ? AW'(rd_sum - SW'(CELLS)) : AW'(rd_sum);

  // physical start of the top row; it becomes the new bottom row on a scroll
  assign top_addr = base_off_r;
  assign bo_sum   = SW'(base_off_r) + SW'(COLUMNS);

  // next cursor and origin
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    base_off_nxt = base_off_r;
    if (cmd.advance) begin
      col_nxt = col_r + COL_W'(1);
    end
    if (cmd.newline) begin
      col_nxt      = '0;
      row_nxt      = row_r + ROW_W'(1);
      row_base_nxt = row_base_r + AW'(COLUMNS);
    end
    if (cmd.scroll) begin
      col_nxt      = '0;
      base_off_nxt = (bo_sum >= SW'(CELLS)) ? '0 : AW'(bo_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      row_base_r <= '0;
      base_off_r <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      row_base_r <= row_base_nxt;
      base_off_r <= base_off_nxt;
    end
  end

endmodule

[rtl/core/text_console_writer.sv]
// text console writer top level: control sequencer, attribute register,
// result register; depends on tcw_pkg, tcw_ram and tcw_cursor
`timescale 1ns / 1ps

// channel   direction  payload              handshake
// in        input      tcw_pkg::in_item_t   in_valid / in_stall
// out       output     tcw_pkg::out_item_t  out_valid / out_stall
// cfg       input      8-bit attribute      cfg_wr_en, no wait
//
// a put or a newline without scroll loads its result when it is taken; a read
// waits in S_READ for the cell ram's registered read data
// a newline on the last row enters S_SCROLL: the ram's single write
// port clears the new bottom row one cell a cycle, the rows themselves stay put
// after reset the ram is cleared one cell a cycle, with in_stall high
// a request is taken in S_IDLE when the result register is empty or drains that cycle

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int ROW_W = $clog2(ROWS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCROLL
  } state_t;

  state_t             state_r;
  logic [AW-1:0]      cnt_r;
  logic [AW-1:0]      sweep_base_r;
  logic               rd_ok_r;
  logic [7:0]         color_r;
  logic               out_valid_r;
  tcw_pkg::out_item_t out_data_r;

  tcw_pkg::cur_cmd_t  cmd;
  tcw_pkg::cur_stat_t stat;
  logic [AW-1:0]      cur_wr_addr;
  logic [AW-1:0]      cur_rd_addr;
  logic [AW-1:0]      top_addr;
  logic [COL_W-1:0]   col_nxt;
  logic [ROW_W-1:0]   row_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [15:0]        ram_wdata;
  logic [15:0]        ram_rdata;

  logic               out_free;
  logic               acc;
  logic               is_read;
  logic               is_nl;
  logic               is_chr;
  logic               res_load;

  // request decode
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign acc      = in_valid && !in_stall;
  assign is_read  = (in_data.mode == tcw_pkg::MODE_READ);
  assign is_nl    = !is_read && (in_data.char_code == tcw_pkg::NEWLINE_CODE);
  assign is_chr   = !is_read && (in_data.char_code != tcw_pkg::NEWLINE_CODE)
                    && (in_data.char_code != tcw_pkg::NULL_CODE);

  // a result is loaded for an accepted put or when a read's data arrives
  assign res_load = (acc && !is_read) || (state_r == S_READ);

  // cursor commands
  assign cmd.advance = acc && is_chr && !stat.col_full;
  assign cmd.newline = acc && is_nl && !stat.at_bottom;
  assign cmd.scroll  = acc && is_nl && stat.at_bottom;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .read_index (in_data.read_index),
    .stat       (stat),
    .wr_addr    (cur_wr_addr),
    .rd_addr    (cur_rd_addr),
    .top_addr   (top_addr),
    .col_nxt    (col_nxt),
    .row_nxt    (row_nxt)
  );

  // ram write port: clearing sweeps or a character store
  always_comb begin
    ram_we    = cmd.advance;
    ram_waddr = cur_wr_addr;
    ram_wdata = {color_r, in_data.char_code};
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
      end
      S_SCROLL: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_base_r + cnt_r;
        ram_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (cur_rd_addr),
    .rd_data (ram_rdata)
  );

  // attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= tcw_pkg::COLOR_RESET;
    end else if (cfg_wr_en) begin
      color_r <= cfg_wr_data;
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      sweep_base_r <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (cnt_r == AW'(CELLS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        S_IDLE: begin
          if (acc) begin
            if (is_read) begin
              rd_ok_r <= stat.read_ok;
              state_r <= S_READ;
            end else begin
              out_data_r.cell_data     <= '0;
              out_data_r.cursor_column <= 7'(col_nxt);
              out_data_r.cursor_row    <= 5'(row_nxt);
              out_data_r.scrolled      <= cmd.scroll;
              if (cmd.scroll) begin
                sweep_base_r <= top_addr;
                cnt_r        <= '0;
                state_r      <= S_SCROLL;
              end
            end
          end
        end
        S_READ: begin
          out_data_r.cell_data     <= rd_ok_r ? ram_rdata : 16'd0;
          out_data_r.cursor_column <= 7'(col_nxt);
          out_data_r.cursor_row    <= 5'(row_nxt);
          out_data_r.scrolled      <= 1'b0;
          state_r                  <= S_IDLE;
        end
        S_SCROLL: begin
          if (cnt_r == AW'(COLUMNS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + AW'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sim/text_console_writer_tb.sv]
// testbench for text_console_writer: directed and random put, newline and read requests
// checked against a cell-level mirror of the screen; depends on tcw_pkg and the rtl
`timescale 1ns / 1ps

module text_console_writer_tb;

  localparam int COLUMNS    = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS       = tcw_pkg::ROWS_DEF;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // screen mirror: predicts each status report and compares the returned ones
  class console_mirror;
    logic [15:0]        cells [CELL_COUNT];
    logic [6:0]         column;
    logic [4:0]         row;
    logic [7:0]         attribute;
    tcw_pkg::out_item_t awaited[$];
    int                 errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      column    = '0;
      row       = '0;
      attribute = tcw_pkg::COLOR_RESET;
      errors    = 0;
    endfunction

    // apply one accepted request to the mirror and queue its status report
    function void note_request(tcw_pkg::in_item_t req);
      tcw_pkg::out_item_t status;
      int                 i;
      status = '0;
      if (req.mode == tcw_pkg::MODE_READ) begin
        if (req.read_index < CELL_COUNT) status.cell_data = cells[req.read_index];
      end else if (req.char_code == tcw_pkg::NEWLINE_CODE) begin
        if (row == 5'(ROWS - 1)) begin
          // bottom row: shift everything up one row and blank the last one
          for (i = 0; i < CELL_COUNT - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
          for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) cells[i] = '0;
          status.scrolled = 1'b1;
        end else begin
          row = row + 5'd1;
        end
        column = '0;
      end else if (req.char_code != tcw_pkg::NULL_CODE && column < 7'(COLUMNS)) begin
        // printable byte; a full line drops it
        cells[int'(row) * COLUMNS + int'(column)] = {attribute, req.char_code};
        column = column + 7'd1;
      end
      status.cursor_column = column;
      status.cursor_row    = row;
      awaited.push_back(status);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    // compare one returned result with the oldest prediction
    function void check_status(tcw_pkg::out_item_t got);
      tcw_pkg::out_item_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      compare_field("cell_data", want.cell_data, got.cell_data);
      compare_field("cursor_column", 16'(want.cursor_column), 16'(got.cursor_column));
      compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
      compare_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
    endfunction
  endclass

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  tcw_pkg::in_item_t  in_data     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  tcw_pkg::out_item_t out_data;
  logic               cfg_wr_en   = 1'b0;
  logic [7:0]         cfg_wr_data = '0;

  console_mirror     mirror = new();
  tcw_pkg::in_item_t request_plan[$];
  int                gen_row   = 0;
  int                idle_pct  = 0;
  int                stall_pct = 0;

  text_console_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) mirror.check_status(out_data);
  end

  // add one request to the plan, tracking the row the cursor will be on
  task automatic push_request(input logic mode, input logic [7:0] code,
                              input logic [10:0] index);
    tcw_pkg::in_item_t req;
    req.mode       = mode;
    req.char_code  = code;
    req.read_index = index;
    if (mode == tcw_pkg::MODE_PUT && code == tcw_pkg::NEWLINE_CODE && gen_row < ROWS - 1)
      gen_row++;
    request_plan.push_back(req);
  endtask

  // read targets: cells near the cursor most often, then anywhere, then off screen
  function automatic logic [10:0] pick_read_index();
    int pick;
    int base_row;
    pick = $urandom_range(99);
    if (pick < 45) begin
      base_row = (gen_row > 0 && $urandom_range(1) == 1) ? gen_row - 1 : gen_row;
      return 11'(base_row * COLUMNS + int'($urandom_range(COLUMNS - 1)));
    end
    if (pick < 85) return 11'($urandom_range(CELL_COUNT - 1));
    return 11'($urandom_range(2047, CELL_COUNT));
  endfunction

  // random text: lines of varied length ended by newline, with reads and noise
  task automatic plan_random(input int count);
    int line_len;
    int k;
    int pick;
    logic [7:0] code;
    while (request_plan.size() < count) begin
      pick = $urandom_range(99);
      if (pick < 55) line_len = $urandom_range(6);
      else if (pick < 85) line_len = $urandom_range(60, 7);
      else line_len = $urandom_range(COLUMNS + 20, COLUMNS);
      for (k = 0; k < line_len; k++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          push_request(1'($urandom), 8'($urandom), 11'($urandom));
        end else if (pick < 22) begin
          push_request(tcw_pkg::MODE_READ, 8'($urandom), pick_read_index());
        end else begin
          code = 8'($urandom_range(255, 1));
          if (code == tcw_pkg::NEWLINE_CODE) code = 8'h20;
          push_request(tcw_pkg::MODE_PUT, code, 11'($urandom));
        end
      end
      push_request(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, 11'($urandom));
    end
  endtask

  // drive one request and wait for it to be taken
  task automatic send_request(input tcw_pkg::in_item_t req);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mirror.note_request(req);
  endtask

  // hold off until every predicted result is back, then let a scroll clear finish
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mirror.awaited.size() != 0) @(negedge clk);
    repeat (COLUMNS + 4) @(negedge clk);
  endtask

  // send the whole plan, pausing once halfway for the block to empty if it has over 40 requests
  task automatic play_requests();
    int total;
    int n;
    total = request_plan.size();
    for (n = 0; n < total; n++) begin
      if (total > 40 && n == total / 2) wait_for_drain();
      send_request(request_plan[n]);
    end
    request_plan.delete();
  endtask

  task automatic write_attribute(input logic [7:0] value);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mirror.attribute = value;
  endtask

  // stimulus
  initial begin
    logic [7:0] phase_attr [4];
    int         phase_idle [4];
    int         phase_stall[4];
    int         p;

    phase_attr  = '{8'hFF, 8'h00, 8'($urandom), 8'h5A};
    phase_idle  = '{0, 71, 0, 24};
    phase_stall = '{0, 0, 71, 24};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: blank reads, zero byte, extreme codes, off-screen reads, newline
    push_request(tcw_pkg::MODE_READ, 8'h00, 11'd0);
    push_request(tcw_pkg::MODE_READ, 8'hFF, 11'(CELL_COUNT - 1));
    push_request(tcw_pkg::MODE_READ, 8'h5A, 11'h7FF);
    push_request(tcw_pkg::MODE_PUT, tcw_pkg::NULL_CODE, 11'h7FF);
    push_request(tcw_pkg::MODE_PUT, 8'h48, 11'd0);
    push_request(tcw_pkg::MODE_PUT, 8'hFF, 11'd0);
    push_request(tcw_pkg::MODE_PUT, 8'h01, 11'h555);
    push_request(tcw_pkg::MODE_READ, 8'h00, 11'd0);
    push_request(tcw_pkg::MODE_READ, 8'h00, 11'd1);
    push_request(tcw_pkg::MODE_READ, 8'h00, 11'd2);
    push_request(tcw_pkg::MODE_READ, 8'h00, 11'd3);
    push_request(tcw_pkg::MODE_READ, tcw_pkg::NEWLINE_CODE, 11'(CELL_COUNT));
    push_request(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, 11'd0);
    push_request(tcw_pkg::MODE_PUT, 8'h7F, 11'd0);
    push_request(tcw_pkg::MODE_PUT, tcw_pkg::NULL_CODE, 11'd0);
    push_request(tcw_pkg::MODE_PUT, 8'h80, 11'd0);
    push_request(tcw_pkg::MODE_READ, 8'h00, 11'(COLUMNS));
    push_request(tcw_pkg::MODE_READ, 8'h00, 11'(COLUMNS + 1));
    push_request(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, 11'h2AA);
    play_requests();

    // random phases, each under its own attribute and idling and stall mix
    for (p = 0; p < 4; p++) begin
      write_attribute(phase_attr[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      plan_random(355);
      play_requests();
    end

    wait_for_drain();
    if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
